// ===== src/ftca_pkg.sv =====
// Shared types and constants for the framed time-of-flight channel averager.
// Holds the sequencer state type, register indexes and default sizes.
// Depends on nothing.
package ftca_pkg;

    // Default sizes of the averager
    localparam int DEF_CHANNELS      = 6;
    localparam int DEF_SAMPLE_BITS   = 24;
    localparam int DEF_FRACTION_BITS = 32;

    // Fixed widths of the input item
    localparam int WORD_W    = 32;
    localparam int WEIGHT_W  = 32;
    localparam int IN_DATA_W = 64;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILER = 2'd1;

    localparam logic [WORD_W-1:0] HEADER_RESET  = 32'hAA0A_AAAA;
    localparam logic [WORD_W-1:0] TRAILER_RESET = 32'hAAFF_FFFF;

    // Per-channel update sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_WRITE
    } t_state;

endpackage

// ===== src/framed_tof_channel_averager.sv =====
// Top level of the framed time-of-flight channel averager.
// Word window, sequencer and per-channel average memory in one module.
// Depends on ftca_pkg.

// Each input item (word, weight) is taken only while idle and shifted into a window of the last
// CHANNELS+1 words. When the item's word equals the trailer register, the oldest window word
// equals the header register and the window is full, the item is consumed as a frame end: the
// input stalls while the channel averages are updated one after another, each through a read,
// difference, two partial products of the 32-bit weight, a sum and a write-back of the average
// memory; a write-back waits while the output side stalls. One output item per channel leaves,
// channel 0 first, with tlast on the last channel. Averages read as zero after reset until first
// written; no clearing pass is needed. The user must write header and trailer through the
// configuration port only while the block is idle; the block does not enforce this.
module framed_tof_channel_averager #(
    parameter int CHANNELS      = ftca_pkg::DEF_CHANNELS,
    parameter int SAMPLE_BITS   = ftca_pkg::DEF_SAMPLE_BITS,
    parameter int FRACTION_BITS = ftca_pkg::DEF_FRACTION_BITS,
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int AVG_BITS   = SAMPLE_BITS + FRACTION_BITS,
    localparam int OUT_DATA_W = ((CH_W + AVG_BITS + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input items
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [ftca_pkg::IN_DATA_W-1:0]   i_s_tdata,   // word [31:0], weight [63:32]
    // result items
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [OUT_DATA_W-1:0]            o_m_tdata,   // channel, then average, zero pad
    output logic                             o_m_tlast,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ftca_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ftca_pkg::WORD_W-1:0]      i_cfg_data
);

    localparam int WIN_DEPTH = CHANNELS + 1;
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
    localparam int HI_BITS   = (AVG_BITS > 32) ? AVG_BITS - 32 : 1;
    localparam int MAG_W     = 32 + HI_BITS;
    localparam int W_W       = ftca_pkg::WORD_W;

    // Configuration registers
    logic [W_W-1:0] r_header;
    logic [W_W-1:0] r_trailer;

    // Word window and fill count
    logic [W_W-1:0]    r_win [WIN_DEPTH];
    logic [FILL_W-1:0] r_fill;

    // Sequencer
    ftca_pkg::t_state r_state, n_state;
    logic [CH_W-1:0]  r_ch;

    // Average memory with per-entry valid bits
    logic [AVG_BITS-1:0] r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_vld;
    logic [AVG_BITS-1:0] r_rd_data;
    logic                r_rd_vld;

    // Update datapath
    logic [ftca_pkg::WEIGHT_W-1:0] r_weight;
    logic [SAMPLE_BITS-1:0]        r_samp;
    logic [AVG_BITS-1:0]           r_avg;
    logic                          r_ge;
    logic [MAG_W-1:0]              r_mag;
    logic [63:0]                   r_plo;
    logic [MAG_W-1:0]              r_phi;
    logic [MAG_W-1:0]              r_step;

    // Output register
    logic                r_out_valid;
    logic [CH_W-1:0]     r_out_ch;
    logic [AVG_BITS-1:0] r_out_avg;
    logic                r_out_last;

    // Combinational control
    logic                w_in_acc;
    logic                w_match;
    logic                w_out_free;
    logic                w_s_tready;
    logic                w_mem_we;
    logic                w_last_ch;
    logic [W_W-1:0]      w_word;
    logic [AVG_BITS-1:0] w_avg_cur;
    logic [AVG_BITS-1:0] w_x;
    logic [AVG_BITS-1:0] w_result;

    assign w_word     = i_s_tdata[W_W-1:0];
    assign w_in_acc   = i_s_tvalid && w_s_tready;
    assign w_match    = (r_fill == FILL_W'(WIN_DEPTH)) && (w_word == r_trailer)
                        && (r_win[0] == r_header);
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_last_ch  = (r_ch == CH_W'(CHANNELS - 1));
    assign w_avg_cur  = r_rd_vld ? r_rd_data : '0;
    assign w_x        = {r_samp, {FRACTION_BITS{1'b0}}};
    assign w_result   = r_ge ? (r_avg + r_step[AVG_BITS-1:0])
                             : (r_avg - r_step[AVG_BITS-1:0]);

    // Next state of the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ftca_pkg::ST_IDLE: begin
                if (w_in_acc && w_match) begin
                    n_state = ftca_pkg::ST_READ;
                end
            end
            ftca_pkg::ST_READ:   n_state = ftca_pkg::ST_DIFF;
            ftca_pkg::ST_DIFF:   n_state = ftca_pkg::ST_MUL_LO;
            ftca_pkg::ST_MUL_LO: n_state = ftca_pkg::ST_MUL_HI;
            ftca_pkg::ST_MUL_HI: n_state = ftca_pkg::ST_SUM;
            ftca_pkg::ST_SUM:    n_state = ftca_pkg::ST_WRITE;
            ftca_pkg::ST_WRITE: begin
                if (w_out_free) begin
                    n_state = w_last_ch ? ftca_pkg::ST_IDLE : ftca_pkg::ST_READ;
                end
            end
            default: n_state = ftca_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        w_s_tready = 1'b0;
        w_mem_we   = 1'b0;
        unique case (r_state)
            ftca_pkg::ST_IDLE:  w_s_tready = 1'b1;
            ftca_pkg::ST_WRITE: w_mem_we   = w_out_free;
            default: begin
                w_s_tready = 1'b0;
                w_mem_we   = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ftca_pkg::ST_IDLE;
            r_ch        <= '0;
            r_fill      <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            r_header    <= ftca_pkg::HEADER_RESET;
            r_trailer   <= ftca_pkg::TRAILER_RESET;
        end else begin
            r_state <= n_state;
            // take configuration writes, drop unknown indexes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ftca_pkg::CFG_HEADER:  r_header  <= i_cfg_data;
                    ftca_pkg::CFG_TRAILER: r_trailer <= i_cfg_data;
                    default: ;
                endcase
            end
            // count window fill, empty it on a frame end
            if (w_in_acc) begin
                if (w_match) begin
                    r_fill <= '0;
                end else if (r_fill != FILL_W'(WIN_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            // advance the channel counter
            if (w_in_acc && w_match) begin
                r_ch <= '0;
            end else if (w_mem_we && !w_last_ch) begin
                r_ch <= r_ch + 1'b1;
            end
            if (w_mem_we) begin
                r_vld[r_ch] <= 1'b1;
            end
            // hold the result until taken
            if (w_mem_we) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Word window: shift in plain words, shift samples out during an update
    always_ff @(posedge i_clk) begin
        if (w_in_acc && !w_match) begin
            for (int k = 0; k < WIN_DEPTH - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[WIN_DEPTH-1] <= w_word;
        end else if (r_state == ftca_pkg::ST_READ) begin
            for (int k = 0; k < WIN_DEPTH - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
        end
    end

    // Average memory: registered read, write-back of the updated entry
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_ch] <= w_result;
        end
        if (r_state == ftca_pkg::ST_READ) begin
            r_rd_data <= r_mem[r_ch];
        end
    end

    // Update datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_match) begin
            r_weight <= i_s_tdata[ftca_pkg::IN_DATA_W-1:W_W];
        end
        unique case (r_state)
            ftca_pkg::ST_READ: begin
                r_samp   <= r_win[1][SAMPLE_BITS-1:0];
                r_rd_vld <= r_vld[r_ch];
            end
            ftca_pkg::ST_DIFF: begin
                r_avg <= w_avg_cur;
                r_ge  <= (w_x >= w_avg_cur);
                r_mag <= MAG_W'((w_x >= w_avg_cur) ? (w_x - w_avg_cur) : (w_avg_cur - w_x));
            end
            ftca_pkg::ST_MUL_LO: begin
                r_plo <= 64'(r_mag[31:0]) * 64'(r_weight);
            end
            ftca_pkg::ST_MUL_HI: begin
                r_phi <= MAG_W'(r_mag[MAG_W-1:32]) * MAG_W'(r_weight);
            end
            ftca_pkg::ST_SUM: begin
                r_step <= r_phi + MAG_W'(r_plo[63:32]);
            end
            default: ;
        endcase
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_out_ch   <= r_ch;
            r_out_avg  <= w_result;
            r_out_last <= w_last_ch;
        end
    end

    // Ports
    always_comb begin
        o_m_tdata                  = '0;
        o_m_tdata[CH_W-1:0]        = r_out_ch;
        o_m_tdata[CH_W +: AVG_BITS] = r_out_avg;
    end
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tlast   = r_out_last;
    assign o_s_tready  = w_s_tready;
    assign o_cfg_ready = 1'b1;

    // Checks
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (!r_out_valid || i_m_tready))
        else $error("result register overwritten before taken");

    a_last_on_final_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata[CH_W-1:0] == CH_W'(CHANNELS - 1)))
        else $error("tlast on a channel other than the final one");

    a_frame_end_starts_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_match) |=> (r_state == ftca_pkg::ST_READ && r_fill == '0))
        else $error("frame end did not start the channel update");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WIN_DEPTH))
        else $error("window fill count beyond window depth");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for the framed time-of-flight channel averager.
// Predicts the six channel averages per frame and compares every result item.
// Depends on ftca_pkg and framed_tof_channel_averager.
module testbench;

    localparam int CHANNELS      = ftca_pkg::DEF_CHANNELS;
    localparam int SAMPLE_BITS   = ftca_pkg::DEF_SAMPLE_BITS;
    localparam int FRACTION_BITS = ftca_pkg::DEF_FRACTION_BITS;
    localparam int WORD_W        = ftca_pkg::WORD_W;
    localparam int WEIGHT_W      = ftca_pkg::WEIGHT_W;
    localparam int WIN_DEPTH     = CHANNELS + 1;
    localparam int CH_W          = 3;
    localparam int AVG_W         = SAMPLE_BITS + FRACTION_BITS;
    localparam int OUT_W         = 64;
    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_SHOWN     = 10;
    localparam int PHASE_ITEMS   = 52;

    // Register indexes beyond the two patterns; writes to them must be ignored
    localparam logic [ftca_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [ftca_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [AVG_W-1:0] average;
        logic             last;
    } t_avg_report;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_s_tvalid;
    logic                              o_s_tready;
    logic [ftca_pkg::IN_DATA_W-1:0]    i_s_tdata;   // word [31:0], weight [63:32]
    logic                              o_m_tvalid;
    logic                              i_m_tready = 1'b0;
    logic [OUT_W-1:0]                  o_m_tdata;   // channel [2:0], average [58:3]
    logic                              o_m_tlast;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [ftca_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [WORD_W-1:0]                 i_cfg_data;

    // Model of the block: patterns, word window and channel averages
    logic [WORD_W-1:0] mdl_header;
    logic [WORD_W-1:0] mdl_trailer;
    logic [WORD_W-1:0] tof_window [WIN_DEPTH];
    int                window_fill;
    logic [AVG_W-1:0]  chan_avg [CHANNELS];
    t_avg_report       avg_due [$];

    int          failures    = 0;
    int          cycle_count = 0;
    int          items_sent  = 0;
    int          burst_left  = 0;
    int          sink_mode   = 0;
    int          sink_left   = 0;
    t_avg_report seen_rep;
    t_avg_report want_rep;

    framed_tof_channel_averager i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock: period 4
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("framed_tof_channel_averager: mismatch");
            $finish;
        end
    end

    // Receiver: switch between always ready, light, alternate and heavy stalls
    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode = $urandom_range(0, 3);
            sink_left = $urandom_range(20, 80);
        end else begin
            sink_left = sink_left - 1;
        end
        case (sink_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= ($urandom_range(0, 2) != 0);
            2: i_m_tready <= sink_left[0];
            default: i_m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Compare each accepted result item with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_rep.channel = o_m_tdata[CH_W-1:0];
            seen_rep.average = o_m_tdata[CH_W +: AVG_W];
            seen_rep.last    = o_m_tlast;
            if (avg_due.size() == 0) begin
                failures = failures + 1;
                if (failures <= MAX_SHOWN) begin
                    $display("unexpected result: channel %0d average %h last %b",
                             seen_rep.channel, seen_rep.average, seen_rep.last);
                end
            end else begin
                want_rep = avg_due.pop_front();
                if (seen_rep !== want_rep) begin
                    failures = failures + 1;
                    if (failures <= MAX_SHOWN) begin
                        $display("expected ch %0d avg %h last %b, got ch %0d avg %h last %b",
                                 want_rep.channel, want_rep.average, want_rep.last,
                                 seen_rep.channel, seen_rep.average, seen_rep.last);
                    end
                end
            end
        end
    end

    // One moving-average step; the weighted step is truncated toward zero
    function automatic logic [AVG_W-1:0] ema_step(input logic [AVG_W-1:0] avg,
                                                  input logic [SAMPLE_BITS-1:0] sample,
                                                  input logic [WEIGHT_W-1:0] w);
        logic [AVG_W-1:0]          target;
        logic [AVG_W+WEIGHT_W-1:0] mag;
        logic [AVG_W+WEIGHT_W-1:0] w_wide;
        logic [AVG_W+WEIGHT_W-1:0] prod;
        target = {sample, {FRACTION_BITS{1'b0}}};
        w_wide = (AVG_W+WEIGHT_W)'(w);
        if (target >= avg) begin
            mag  = (AVG_W+WEIGHT_W)'(target - avg);
            prod = mag * w_wide;
            return avg + prod[AVG_W+WEIGHT_W-1:WEIGHT_W];
        end
        mag  = (AVG_W+WEIGHT_W)'(avg - target);
        prod = mag * w_wide;
        return avg - prod[AVG_W+WEIGHT_W-1:WEIGHT_W];
    endfunction

    // Shift a word into the window, or close a frame and queue its averages
    task automatic absorb_word(input logic [WORD_W-1:0] word, input logic [WEIGHT_W-1:0] weight);
        t_avg_report rep;
        int          ch;
        if (window_fill >= WIN_DEPTH && word == mdl_trailer && tof_window[0] == mdl_header) begin
            for (ch = 0; ch < CHANNELS; ch++) begin
                chan_avg[ch] = ema_step(chan_avg[ch], tof_window[ch+1][SAMPLE_BITS-1:0], weight);
                rep.channel  = ch[CH_W-1:0];
                rep.average  = chan_avg[ch];
                rep.last     = (ch == CHANNELS - 1);
                avg_due.insert(avg_due.size(), rep);
            end
            for (ch = 0; ch < WIN_DEPTH; ch++) begin
                tof_window[ch] = '0;
            end
            window_fill = 0;
        end else begin
            for (ch = 0; ch < WIN_DEPTH - 1; ch++) begin
                tof_window[ch] = tof_window[ch+1];
            end
            tof_window[WIN_DEPTH-1] = word;
            if (window_fill < WIN_DEPTH) begin
                window_fill = window_fill + 1;
            end
        end
    endtask

    // Send one item; hold valid within a burst, drop it for a gap between bursts
    task automatic send_item(input logic [WORD_W-1:0] word, input logic [WEIGHT_W-1:0] weight);
        int gap;
        i_s_tdata  <= {weight, word};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        absorb_word(word, weight);
        items_sent = items_sent + 1;
        if (burst_left > 0) begin
            burst_left = burst_left - 1;
        end else begin
            gap = $urandom_range(1, 6);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Stop sending, wait for every predicted result, then let the block go quiet
    task automatic settle_block();
        i_s_tvalid <= 1'b0;
        while (avg_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the patterns, optionally preceded by writes to the spare indexes
    task automatic program_patterns(input logic [WORD_W-1:0] hdr, input logic [WORD_W-1:0] trl,
                                    input bit with_spare);
        logic [ftca_pkg::CFG_IDX_W-1:0] idx [4];
        logic [WORD_W-1:0]              val [4];
        int                             n;
        int                             k;
        n = 0;
        if (with_spare) begin
            idx[0] = CFG_SPARE_2;
            val[0] = $urandom;
            idx[1] = CFG_SPARE_3;
            val[1] = $urandom;
            n = 2;
        end
        idx[n]   = ftca_pkg::CFG_HEADER;
        val[n]   = hdr;
        idx[n+1] = ftca_pkg::CFG_TRAILER;
        val[n+1] = trl;
        n = n + 2;
        for (k = 0; k < n; k++) begin
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            i_cfg_valid <= 1'b1;
            do @(posedge i_clk); while (!o_cfg_ready);
            if (idx[k] == ftca_pkg::CFG_HEADER) begin
                mdl_header = val[k];
            end else if (idx[k] == ftca_pkg::CFG_TRAILER) begin
                mdl_trailer = val[k];
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Header, the given samples, trailer carrying the weight
    task automatic send_listed_frame(input logic [CHANNELS-1:0][WORD_W-1:0] samples,
                                     input logic [WEIGHT_W-1:0] weight);
        int ch;
        send_item(mdl_header, $urandom);
        for (ch = 0; ch < CHANNELS; ch++) begin
            send_item(samples[ch], $urandom);
        end
        send_item(mdl_trailer, weight);
    endtask

    function automatic logic [WORD_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return '1;
            2: return 32'h00FF_FFFF;
            3: return 32'hFF00_0000;
            4: return mdl_header;
            default: return $urandom;
        endcase
    endfunction

    // Weights: extremes, the 1/(10n) schedule, or anything
    function automatic logic [WEIGHT_W-1:0] pick_weight();
        logic [63:0] q;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3, 4: begin
                q = 64'h1_0000_0000 / (64'd10 * $urandom_range(1, 200));
                return q[WEIGHT_W-1:0];
            end
            default: return $urandom;
        endcase
    endfunction

    // Header, n samples and trailer; n other than CHANNELS gives a broken frame
    task automatic send_frame(input int n, input logic [WEIGHT_W-1:0] weight);
        int k;
        send_item(mdl_header, $urandom);
        for (k = 0; k < n; k++) begin
            send_item(pick_sample(), $urandom);
        end
        send_item(mdl_trailer, weight);
    endtask

    // Mostly well-formed frames, some broken frames, stray markers and noise
    task automatic send_random_sequence();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
            send_frame(CHANNELS, pick_weight());
        end else if (kind == 7) begin
            n = $urandom_range(CHANNELS - 2, CHANNELS + 2);
            if (n == CHANNELS) begin
                n = CHANNELS + 1;
            end
            send_frame(n, pick_weight());
        end else if (kind == 8) begin
            case ($urandom_range(0, 2))
                0: send_item(mdl_trailer, pick_weight());
                1: send_item(mdl_header, $urandom);
                default: send_item(mdl_trailer ^ (32'd1 << $urandom_range(0, 31)), pick_weight());
            endcase
        end else begin
            repeat ($urandom_range(1, 4)) send_item($urandom, $urandom);
        end
    endtask

    // Reset patterns; extreme samples at full weight, then zero weight
    task automatic test_frame_extremes();
        send_listed_frame({32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_FFFF,
                           32'hFF00_0000, 32'h0000_0001, 32'h1234_5678}, '1);
        send_listed_frame({32'h0080_0000, 32'h00FF_FFFE, 32'h0000_0000,
                           32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F}, '0);
    endtask

    // Extreme patterns, spare indexes, a trailer on a window that is not yet full
    task automatic test_pattern_registers();
        settle_block();
        program_patterns('0, '1, 1'b1);
        // window empty after the last frame: zero header must not match
        send_item('1, '1);
        send_listed_frame({32'h0000_0010, 32'hFF00_0001, 32'h0000_0003,
                           32'h00FF_0000, 32'h0000_0100, 32'h0000_00AA}, 32'h8000_0000);
        settle_block();
        program_patterns('1, '0, 1'b0);
        send_listed_frame({32'h0000_0002, 32'h0080_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'hABCD_EF01, 32'h00FF_FFFF}, 32'h1999_9999);
    endtask

    // Random traffic in phases; each phase starts from an idle, drained block
    task automatic test_random_traffic();
        int phase;
        int phase_start;
        logic [WORD_W-1:0] hdr;
        for (phase = 0; phase < 4; phase++) begin
            settle_block();
            case (phase)
                0: program_patterns(ftca_pkg::HEADER_RESET, ftca_pkg::TRAILER_RESET, 1'b1);
                1: program_patterns($urandom, $urandom, 1'b0);
                2: begin
                    hdr = $urandom;
                    program_patterns(hdr, hdr, 1'b1);
                end
                default: program_patterns(ftca_pkg::HEADER_RESET, ftca_pkg::TRAILER_RESET, 1'b0);
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                send_random_sequence();
            end
        end
    endtask

    initial begin
        int ch;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= ftca_pkg::CFG_HEADER;
        i_cfg_data  <= '0;
        mdl_header  = ftca_pkg::HEADER_RESET;
        mdl_trailer = ftca_pkg::TRAILER_RESET;
        window_fill = 0;
        for (ch = 0; ch < WIN_DEPTH; ch++) begin
            tof_window[ch] = '0;
        end
        for (ch = 0; ch < CHANNELS; ch++) begin
            chan_avg[ch] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_frame_extremes();
        test_pattern_registers();
        test_random_traffic();

        // Drain and decide
        settle_block();
        if (failures == 0 && avg_due.size() == 0) begin
            $display("framed_tof_channel_averager: match");
        end else begin
            $display("framed_tof_channel_averager: mismatch");
        end
        $finish;
    end

endmodule
